// ===== rtl/gcm_pkg.sv =====
`timescale 1ns / 1ps

package gcm_pkg;

  localparam int POS_W  = 16;
  localparam int SP_W   = 30;   // 10000 * position
  localparam int D_W    = 28;   // offset into a segment
  localparam int DEN_W  = 28;   // segment length times full scale
  localparam int N_W    = 36;   // slope * offset, plus ceiling bias
  localparam int RCP_W  = 10;
  localparam int RCP_SH = 36;
  localparam int NSTG   = 7;

  localparam longint unsigned POS_MAX = (64'd1 << POS_W) - 64'd1;

  // segment stops, scaled by 10000 * full scale
  localparam logic [SP_W-1:0] STOP_1 = SP_W'(64'd1600 * POS_MAX);
  localparam logic [SP_W-1:0] STOP_2 = SP_W'(64'd4200 * POS_MAX);
  localparam logic [SP_W-1:0] STOP_3 = SP_W'(64'd6425 * POS_MAX);
  localparam logic [SP_W-1:0] STOP_4 = SP_W'(64'd8575 * POS_MAX);

  localparam longint unsigned DEN64_0 = 64'd1600 * POS_MAX;
  localparam longint unsigned DEN64_1 = 64'd2600 * POS_MAX;
  localparam longint unsigned DEN64_2 = 64'd2225 * POS_MAX;
  localparam longint unsigned DEN64_3 = 64'd2150 * POS_MAX;
  localparam longint unsigned DEN64_4 = 64'd1425 * POS_MAX;

  localparam logic [DEN_W-1:0] DEN_0 = DEN_W'(DEN64_0);
  localparam logic [DEN_W-1:0] DEN_1 = DEN_W'(DEN64_1);
  localparam logic [DEN_W-1:0] DEN_2 = DEN_W'(DEN64_2);
  localparam logic [DEN_W-1:0] DEN_3 = DEN_W'(DEN64_3);
  localparam logic [DEN_W-1:0] DEN_4 = DEN_W'(DEN64_4);

  // floor(2^RCP_SH / den): quotient estimate is exact or one low
  localparam logic [RCP_W-1:0] RCP_0 = RCP_W'((64'd1 << RCP_SH) / DEN64_0);
  localparam logic [RCP_W-1:0] RCP_1 = RCP_W'((64'd1 << RCP_SH) / DEN64_1);
  localparam logic [RCP_W-1:0] RCP_2 = RCP_W'((64'd1 << RCP_SH) / DEN64_2);
  localparam logic [RCP_W-1:0] RCP_3 = RCP_W'((64'd1 << RCP_SH) / DEN64_3);
  localparam logic [RCP_W-1:0] RCP_4 = RCP_W'((64'd1 << RCP_SH) / DEN64_4);

  localparam logic [2:0] SEG_0 = 3'd0;
  localparam logic [2:0] SEG_1 = 3'd1;
  localparam logic [2:0] SEG_2 = 3'd2;
  localparam logic [2:0] SEG_3 = 3'd3;
  localparam logic [2:0] SEG_4 = 3'd4;

  localparam logic [1:0] CH_RED = 2'd0;
  localparam logic [1:0] CH_GRN = 2'd1;
  localparam logic [1:0] CH_BLU = 2'd2;

  typedef struct packed {
    logic [7:0]       start;
    logic [7:0]       slope;
    logic             fall;
    logic [DEN_W-1:0] den;
    logic [RCP_W-1:0] rcp;
  } coef_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

  function automatic logic [SP_W-1:0] seg_off(input logic [2:0] seg);
    logic [SP_W-1:0] o;
    case (seg)
      SEG_1:   o = STOP_1;
      SEG_2:   o = STOP_2;
      SEG_3:   o = STOP_3;
      SEG_4:   o = STOP_4;
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic coef_t seg_coef(input logic [2:0] seg, input logic [1:0] ch);
    coef_t      c;
    logic [7:0] st;
    logic [7:0] sl;
    logic       fl;
    st = 8'd0;
    sl = 8'd0;
    fl = 1'b0;
    case (seg)
      SEG_0: begin
        c.den = DEN_0;
        c.rcp = RCP_0;
        case (ch)
          CH_RED:  begin st = 8'd0;   sl = 8'd32;  fl = 1'b0; end
          CH_GRN:  begin st = 8'd7;   sl = 8'd100; fl = 1'b0; end
          CH_BLU:  begin st = 8'd100; sl = 8'd103; fl = 1'b0; end
          default: begin st = 8'd0;   sl = 8'd0;   fl = 1'b0; end
        endcase
      end
      SEG_1: begin
        c.den = DEN_1;
        c.rcp = RCP_1;
        case (ch)
          CH_RED:  begin st = 8'd32;  sl = 8'd205; fl = 1'b0; end
          CH_GRN:  begin st = 8'd107; sl = 8'd148; fl = 1'b0; end
          CH_BLU:  begin st = 8'd203; sl = 8'd42;  fl = 1'b0; end
          default: begin st = 8'd0;   sl = 8'd0;   fl = 1'b0; end
        endcase
      end
      SEG_2: begin
        c.den = DEN_2;
        c.rcp = RCP_2;
        case (ch)
          CH_RED:  begin st = 8'd237; sl = 8'd18;  fl = 1'b0; end
          CH_GRN:  begin st = 8'd255; sl = 8'd85;  fl = 1'b1; end
          CH_BLU:  begin st = 8'd255; sl = 8'd255; fl = 1'b1; end
          default: begin st = 8'd0;   sl = 8'd0;   fl = 1'b0; end
        endcase
      end
      SEG_3: begin
        c.den = DEN_3;
        c.rcp = RCP_3;
        case (ch)
          CH_RED:  begin st = 8'd255; sl = 8'd255; fl = 1'b1; end
          CH_GRN:  begin st = 8'd170; sl = 8'd168; fl = 1'b1; end
          default: begin st = 8'd0;   sl = 8'd0;   fl = 1'b0; end
        endcase
      end
      default: begin
        c.den = DEN_4;
        c.rcp = RCP_4;
        case (ch)
          CH_GRN:  begin st = 8'd2;   sl = 8'd2;   fl = 1'b1; end
          default: begin st = 8'd0;   sl = 8'd0;   fl = 1'b0; end
        endcase
      end
    endcase
    c.start = st;
    c.slope = sl;
    c.fall  = fl;
    return c;
  endfunction

endpackage

// ===== rtl/gcm_seg.sv =====
`timescale 1ns / 1ps

module gcm_seg import gcm_pkg::*; (
  input  logic                clk,
  input  pipe_ctl_t           ctl,
  input  logic [POS_W-1:0]    pos,
  output logic [D_W-1:0]      d_r,
  output coef_t [2:0]         cf_r
);

  logic [SP_W-1:0] sp_r;
  logic [2:0]      seg;
  logic [SP_W-1:0] d_full;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      sp_r <= SP_W'(pos) * SP_W'(14'd10000);
    end
  end

  // each segment includes its upper stop
  always_comb begin
    if (sp_r <= STOP_1) begin
      seg = SEG_0;
    end else if (sp_r <= STOP_2) begin
      seg = SEG_1;
    end else if (sp_r <= STOP_3) begin
      seg = SEG_2;
    end else if (sp_r <= STOP_4) begin
      seg = SEG_3;
    end else begin
      seg = SEG_4;
    end
    d_full = sp_r - seg_off(seg);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      d_r     <= d_full[D_W-1:0];
      cf_r[0] <= seg_coef(seg, CH_RED);
      cf_r[1] <= seg_coef(seg, CH_GRN);
      cf_r[2] <= seg_coef(seg, CH_BLU);
    end
  end

endmodule

// ===== rtl/gcm_div.sv =====
`timescale 1ns / 1ps

module gcm_div import gcm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  pipe_ctl_t       ctl,
  input  logic [D_W-1:0]  d,
  input  coef_t           cf,
  output logic [7:0]      res_r
);

  logic [N_W-1:0]          n2_r, n3_r, n4_r;
  coef_t                   c2_r, c3_r, c4_r, c5_r;
  logic [7:0]              q3_r, q4_r, q5_r;
  logic [N_W-1:0]          qd4_r;
  logic [N_W+RCP_W-1:0]    prod;
  logic [N_W-1:0]          rem;
  logic                    adj;
  logic [N_W-1:0]          bias;

  // falling channels need the ceiling: bias by den - 1
  assign bias = cf.fall ? N_W'(cf.den - 1'b1) : '0;
  assign prod = n2_r * c2_r.rcp;
  assign rem  = n4_r - qd4_r;
  assign adj  = rem >= N_W'(c4_r.den);

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      n2_r <= N_W'(cf.slope) * N_W'(d) + bias;
      c2_r <= cf;
    end
    if (ctl.en[3]) begin
      q3_r <= prod[RCP_SH+7:RCP_SH];
      n3_r <= n2_r;
      c3_r <= c2_r;
    end
    if (ctl.en[4]) begin
      qd4_r <= N_W'(q3_r) * N_W'(c3_r.den);
      q4_r  <= q3_r;
      n4_r  <= n3_r;
      c4_r  <= c3_r;
    end
    if (ctl.en[5]) begin
      q5_r <= q4_r + {7'd0, adj};
      c5_r <= c4_r;
    end
    if (ctl.en[6]) begin
      if (!c5_r.fall) begin
        res_r <= c5_r.start + q5_r;
      end else if (q5_r > c5_r.start) begin
        res_r <= 8'd0;
      end else begin
        res_r <= c5_r.start - q5_r;
      end
    end
  end

`ifndef SYNTHESIS
  // reciprocal estimate must be exact or one low
  a_quot_est: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld[4] |-> (n4_r >= qd4_r) && (rem < (N_W'(c4_r.den) << 1)))
    else $error("quotient estimate out of range");
`endif

endmodule

// ===== rtl/gradient_color_map.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle when the output is not stalled; a new position can then enter every clock.
// The path is set by the 7-stage pipeline: scale, segment select, slope
// multiply, reciprocal multiply, back-multiply, correction, output register.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
module gradient_color_map import gcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

  logic [NSTG-1:0] v_r, v_nxt, rdy;
  pipe_ctl_t       ctl;
  logic [D_W-1:0]  d;
  coef_t [2:0]     cf;
  logic [7:0]      red, green, blue;

  // a stage may load when empty or when the next one moves
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_tvalid;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctl.en  = rdy;
  assign ctl.vld = v_r;

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = {blue, green, red};

  gcm_seg u_seg (
    .clk  (clk),
    .ctl  (ctl),
    .pos  (in_tdata[POS_W-1:0]),
    .d_r  (d),
    .cf_r (cf)
  );

  gcm_div u_div_red (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .d     (d),
    .cf    (cf[0]),
    .res_r (red)
  );

  gcm_div u_div_grn (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .d     (d),
    .cf    (cf[1]),
    .res_r (green)
  );

  gcm_div u_div_blu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .d     (d),
    .cf    (cf[2]),
    .res_r (blue)
  );

`ifndef SYNTHESIS
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_tready)
    else $error("input stalled with a free stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat not in first stage");

  a_last_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-2] && rdy[NSTG-1] |=> v_r[NSTG-1])
    else $error("beat lost before output register");
`endif

endmodule

// ===== sim/tb_gradient_color_map.sv =====
`timescale 1ns / 1ps
module tb_gradient_color_map;
  import gcm_pkg::*;

  // same packing as out_tdata: red in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct {
    logic [POS_W-1:0] pos;
    color_t           color;
  } color_exp_t;

  class color_scoreboard;
    color_exp_t  color_q[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    static function logic [7:0] ramp_up(longint unsigned base, longint unsigned slope,
                                        longint unsigned off, longint unsigned span);
      return 8'(base + (slope * off) / span);
    endfunction

    // ceiling on the drop, clamped at zero
    static function logic [7:0] ramp_down(longint unsigned base, longint unsigned slope,
                                          longint unsigned off, longint unsigned span);
      longint unsigned drop;
      drop = (slope * off + span - 1) / span;
      return (drop > base) ? 8'd0 : 8'(base - drop);
    endfunction

    static function color_t map_position(logic [POS_W-1:0] pos);
      longint unsigned full;
      longint unsigned scaled;
      longint unsigned off;
      longint unsigned span;
      color_t          c;
      full   = POS_MAX;
      scaled = 64'd10000 * pos;
      if (scaled <= 64'd1600 * full) begin
        off     = scaled;
        span    = 64'd1600 * full;
        c.red   = ramp_up(0, 32, off, span);
        c.green = ramp_up(7, 100, off, span);
        c.blue  = ramp_up(100, 103, off, span);
      end else if (scaled <= 64'd4200 * full) begin
        off     = scaled - 64'd1600 * full;
        span    = 64'd2600 * full;
        c.red   = ramp_up(32, 205, off, span);
        c.green = ramp_up(107, 148, off, span);
        c.blue  = ramp_up(203, 42, off, span);
      end else if (scaled <= 64'd6425 * full) begin
        off     = scaled - 64'd4200 * full;
        span    = 64'd2225 * full;
        c.red   = ramp_up(237, 18, off, span);
        c.green = ramp_down(255, 85, off, span);
        c.blue  = ramp_down(255, 255, off, span);
      end else if (scaled <= 64'd8575 * full) begin
        off     = scaled - 64'd6425 * full;
        span    = 64'd2150 * full;
        c.red   = ramp_down(255, 255, off, span);
        c.green = ramp_down(170, 168, off, span);
        c.blue  = 8'd0;
      end else begin
        off     = scaled - 64'd8575 * full;
        span    = 64'd1425 * full;
        c.red   = 8'd0;
        c.green = ramp_down(2, 2, off, span);
        c.blue  = 8'd0;
      end
      return c;
    endfunction

    function void note_position(logic [POS_W-1:0] pos);
      color_exp_t e;
      e.pos   = pos;
      e.color = map_position(pos);
      color_q.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      fails++;
    endtask

    task check_color(color_t got);
      color_exp_t e;
      if (color_q.size() == 0) begin
        report($sformatf("color beat %06h with no position pending", got));
        return;
      end
      e = color_q.pop_front();
      if (got.red !== e.color.red)
        report($sformatf("pos %0d red %0d, want %0d", e.pos, got.red, e.color.red));
      if (got.green !== e.color.green)
        report($sformatf("pos %0d green %0d, want %0d", e.pos, got.green, e.color.green));
      if (got.blue !== e.color.blue)
        report($sformatf("pos %0d blue %0d, want %0d", e.pos, got.blue, e.color.blue));
    endtask

    function int pending();
      return color_q.size();
    endfunction
  endclass

  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 196;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [POS_W-1:0] in_tdata   = '0;
  logic             out_tready = 1'b0;
  wire              in_tready;
  wire              out_tvalid;
  wire  [23:0]      out_tdata;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  color_scoreboard sb = new();

  // zero, full scale, both sides of every stop, and some bit patterns
  logic [POS_W-1:0] corner_pos [18] = '{
    16'd0, 16'd1, 16'd65534, 16'd65535,
    16'd10485, 16'd10486, 16'd27524, 16'd27525,
    16'd42106, 16'd42107, 16'd56196, 16'd56197,
    16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h00FF, 16'hFF00
  };

  int unsigned idle_by_phase  [4] = '{0, 83, 0, 11};
  int unsigned stall_by_phase [4] = '{0, 0, 83, 11};
  int unsigned stop_permyriad [4] = '{1600, 4200, 6425, 8575};

  gradient_color_map u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_position(in_tdata);
      if (out_tvalid && out_tready) sb.check_color(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_position(input logic [POS_W-1:0] pos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pos;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned     kind;
    longint unsigned knee;
    kind = $urandom_range(9);
    if (kind < 6) begin
      return POS_W'($urandom);
    end else if (kind < 9) begin
      // last code of a segment, give or take a few
      knee = (longint'(stop_permyriad[$urandom_range(3)]) * POS_MAX) / 10000;
      return POS_W'(knee + $urandom_range(8) - 4);
    end else begin
      return $urandom_range(1) ? POS_W'($urandom_range(3)) : POS_W'(POS_MAX - $urandom_range(3));
    end
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (corner_pos[i]) send_position(corner_pos[i]);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      repeat (PHASE_ITEMS) send_position(pick_position());
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== gradient_color_map.f =====
rtl/gcm_pkg.sv
rtl/gcm_seg.sv
rtl/gcm_div.sv
rtl/gradient_color_map.sv
sim/tb_gradient_color_map.sv
